FILE: rtl/rolling_return_volatility_top_macros.svh
// Assertion helpers for the rolling volatility block.
`ifndef ROLLING_RETURN_VOLATILITY_TOP_MACROS_SVH
`define ROLLING_RETURN_VOLATILITY_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RRV_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RRV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rrv_pkg.sv
package rrv_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int ENTRY_W = 33;
    localparam int S1_W = 33 + AW;
    localparam int AS1_W = S1_W - 1;
    localparam int S2_W = 62 + AW;
    localparam int NUM_W = 2 * AS1_W;
    localparam int DIV_W = (NUM_W > 56) ? NUM_W : 56;
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam int ONE_Q24 = 16777216;
    localparam logic [31:0] RET_MAX = 32'h7FFF_FFFF;
    localparam logic [6:0] WINDOW_RESET = 7'd20;
    localparam int SQRT_STEPS = 32;

    typedef logic [2:0] state_t;

endpackage

FILE: rtl/rrv_ram.sv
module rrv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/rolling_return_volatility_top.sv
// Rolling volatility of simple returns. Each item is one closing price
// (unsigned Q16.16); each item gives exactly one result. From the second item
// on the block forms close/previous - 1 as signed Q8.24 (saturating high) and
// stores it, with a valid mark, in a 64-entry ring held in a single-port-write,
// registered-read RAM. Once window_length items have come before the current
// one it reports the sample standard deviation (n-1 divisor) of the valid
// returns in the last window_length entries, as Q8.24 truncated, together with
// the count of valid returns. For each item the block takes the item, runs the
// shared restoring divider for the return (76 quotient bits), reads the RAM
// once per cycle over the window, drains the read, square and accumulate stages
// and decides, runs a 38-step shift-add square of the sum, the same divider
// for the variance and a 32-step square root, and hands the result over. Items
// with no return or no full window skip the steps that do not apply. One item
// is worked on at a time; the next item may enter while the previous result
// still waits at the output register. window_length is to be written through
// window_length_we only while idle; the block itself does not enforce this.
module rolling_return_volatility_top
    import rrv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        window_length_we,
    input  logic [6:0]  window_length,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] close_price,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        volatility_valid,
    output logic [31:0] volatility,
    output logic [6:0]  returns_used
);

`include "rolling_return_volatility_top_macros.svh"

    localparam state_t ST_IDLE = 3'd0;
    localparam state_t ST_DIVR = 3'd1;
    localparam state_t ST_SCAN = 3'd2;
    localparam state_t ST_SQ   = 3'd3;
    localparam state_t ST_DIVV = 3'd4;
    localparam state_t ST_SQRT = 3'd5;
    localparam state_t ST_FIN  = 3'd6;

    // control
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [31:0]        prev_reg, prev_next;
    logic [6:0]         wlen_reg, wlen_next;
    logic               ovalid_reg, ovalid_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]   iss_reg, iss_next;
    logic               rdv_reg, rdv_next;
    logic               v1_reg, v1_next;

    // payload
    logic [AW-1:0]      last_reg, last_next;
    logic [CNT_W-1:0]   w_reg, w_next;
    logic               full_reg, full_next;
    logic [AW-1:0]      raddr_reg, raddr_next;
    logic signed [31:0] x1_reg, x1_next;
    logic [63:0]        sq1_reg, sq1_next;
    logic signed [S1_W-1:0] s1_reg, s1_next;
    logic [S2_W-1:0]    s2_reg, s2_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [DIV_W-1:0]   dq_reg, dq_next;
    logic [31:0]        drem_reg, drem_next;
    logic [31:0]        dd_reg, dd_next;
    logic [NUM_W-1:0]   mcand_reg, mcand_next;
    logic [AS1_W-1:0]   mplier_reg, mplier_next;
    logic [NUM_W-1:0]   acc_reg, acc_next;
    logic [63:0]        sval_reg, sval_next;
    logic [33:0]        srem_reg, srem_next;
    logic [31:0]        root_reg, root_next;
    logic               ovol_ok_reg, ovol_ok_next;
    logic [31:0]        ovol_reg, ovol_next;
    logic [6:0]         oused_reg, oused_next;

    // ring RAM
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    rrv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (raddr_reg),
        .rdata (ram_rdata)
    );

    // shared datapath pieces
    logic [32:0]        div_t;
    logic               div_bit;
    logic [31:0]        div_rem;
    logic [31:0]        ratio_ret;
    logic [31:0]        wl_ext;
    logic [CNT_W-1:0]   w_clamp;
    logic               issue;
    logic signed [31:0] rx;
    logic [31:0]        rax;
    logic [AS1_W-1:0]   as1;
    logic [NUM_W-1:0]   ns2;
    logic [NUM_W-1:0]   num;
    logic [2*CNT_W-1:0] nn1;
    logic [35:0]        sq_t;
    logic [35:0]        sq_trial;
    logic               sq_bit;
    logic               out_free;
    logic               res_ok;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign volatility_valid = ovol_ok_reg;
    assign volatility = ovol_reg;
    assign returns_used = oused_reg;

    assign out_free = !ovalid_reg || out_ready;

    // a result needs a full window of at least two entries and two valid returns
    assign res_ok = full_reg && (w_reg >= CNT_W'(2)) && (n_reg >= CNT_W'(2));

    // one restoring divide step
    assign div_t = {drem_reg, dq_reg[DIV_W-1]};
    assign div_bit = (div_t >= {1'b0, dd_reg});
    assign div_rem = div_bit ? 32'(div_t - {1'b0, dd_reg}) : div_t[31:0];

    // saturate the quotient of the return divide
    always_comb
    begin
        if (dq_reg > DIV_W'(64'(RET_MAX) + 64'(ONE_Q24)))
        begin
            ratio_ret = RET_MAX;
        end
        else
        begin
            ratio_ret = 32'(dq_reg - DIV_W'(ONE_Q24));
        end
    end

    assign wl_ext = {25'd0, wlen_reg};
    assign w_clamp = (wl_ext > 32'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : CNT_W'(wl_ext);

    assign issue = (state_reg == ST_SCAN) && full_reg && (iss_reg < w_reg);

    assign rx = signed'(ram_rdata[31:0]);
    assign rax = rx[31] ? 32'(-rx) : 32'(rx);

    assign as1 = s1_reg[S1_W-1] ? AS1_W'(-s1_reg) : AS1_W'(s1_reg);
    assign ns2 = NUM_W'(s2_reg) * NUM_W'(n_reg);
    assign num = ns2 - acc_reg;
    assign nn1 = (2*CNT_W)'(n_reg) * (2*CNT_W)'(n_reg - CNT_W'(1));

    // one square root digit
    assign sq_t = {srem_reg, sval_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_bit = (sq_t >= sq_trial);

    always_comb
    begin
        state_next = state_reg;
        seen_next = seen_reg;
        pos_next = pos_reg;
        prev_next = prev_reg;
        wlen_next = window_length_we ? window_length : wlen_reg;
        ovalid_next = ovalid_reg && !out_ready;
        step_next = step_reg;
        iss_next = iss_reg;
        rdv_next = issue;
        v1_next = 1'b0;
        last_next = last_reg;
        w_next = w_reg;
        full_next = full_reg;
        raddr_next = raddr_reg;
        x1_next = x1_reg;
        sq1_next = sq1_reg;
        s1_next = s1_reg;
        s2_next = s2_reg;
        n_next = n_reg;
        dq_next = dq_reg;
        drem_next = drem_reg;
        dd_next = dd_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        acc_next = acc_reg;
        sval_next = sval_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        ovol_ok_next = ovol_ok_reg;
        ovol_next = ovol_reg;
        oused_next = oused_reg;
        ram_we = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = '0;
        ram_re = issue;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = pos_reg;
                    w_next = w_clamp;
                    full_next = (seen_reg >= w_clamp);
                    raddr_next = pos_reg;
                    iss_next = '0;
                    s1_next = '0;
                    s2_next = '0;
                    n_next = '0;
                    prev_next = close_price;
                    if (seen_reg < CNT_W'(WINDOW_MAX))
                    begin
                        seen_next = seen_reg + CNT_W'(1);
                    end
                    state_next = ST_SCAN;
                    if (seen_reg != '0)
                    begin
                        // advance the ring on every return, valid or not
                        pos_next = (32'(pos_reg) + 32'd1 >= 32'(WINDOW_MAX))
                                   ? '0 : pos_reg + AW'(1);
                        if (prev_reg == '0)
                        begin
                            ram_we = 1'b1;
                            ram_wdata = '0;
                        end
                        else
                        begin
                            dq_next = DIV_W'({close_price, 24'd0});
                            drem_next = '0;
                            dd_next = prev_reg;
                            step_next = STEP_W'(DIV_W);
                            state_next = ST_DIVR;
                        end
                    end
                end
            end

            ST_DIVR:
            begin
                dq_next = {dq_reg[DIV_W-2:0], div_bit};
                drem_next = div_rem;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    ram_we = 1'b1;
                    ram_waddr = last_reg;
                    ram_wdata = {1'b1, ratio_ret};
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (issue)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                    raddr_next = (raddr_reg == '0) ? AW'(WINDOW_MAX - 1)
                                                   : raddr_reg - AW'(1);
                end
                // stage one: square valid entries
                if (rdv_reg && ram_rdata[32])
                begin
                    v1_next = 1'b1;
                    x1_next = rx;
                    sq1_next = 64'(rax) * 64'(rax);
                end
                // stage two: accumulate
                if (v1_reg)
                begin
                    s1_next = s1_reg + S1_W'(x1_reg);
                    s2_next = s2_reg + S2_W'(sq1_reg);
                    n_next = n_reg + CNT_W'(1);
                end
                if (!issue && !rdv_reg && !v1_reg)
                begin
                    if (res_ok)
                    begin
                        mcand_next = NUM_W'(as1);
                        mplier_next = as1;
                        acc_next = '0;
                        step_next = STEP_W'(AS1_W - 1);
                        state_next = ST_SQ;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_SQ:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[NUM_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_DIVV;
                end
            end

            ST_DIVV:
            begin
                dq_next = {dq_reg[DIV_W-2:0], div_bit};
                drem_next = div_rem;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    sval_next = dq_next[63:0];
                    srem_next = '0;
                    root_next = '0;
                    step_next = STEP_W'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
            end

            ST_SQRT:
            begin
                sval_next = {sval_reg[61:0], 2'b00};
                srem_next = sq_bit ? 34'(sq_t - sq_trial) : sq_t[33:0];
                root_next = {root_reg[30:0], sq_bit};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                // hand the result over only once the output register is free
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ovol_ok_next = res_ok;
                    ovol_next = res_ok ? root_reg : '0;
                    oused_next = full_reg ? 7'(n_reg) : 7'd0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // load the variance divide as the square finishes
        if (state_reg == ST_SQ && step_reg == '0)
        begin
            dq_next = DIV_W'(num - (mplier_reg[0] ? mcand_reg : '0));
            drem_next = '0;
            dd_next = 32'(nn1);
            step_next = STEP_W'(DIV_W - 1);
        end
    end

    // hold the output payload while an item waits to be taken
    logic load_out;
    assign load_out = (state_reg == ST_FIN) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seen_reg <= '0;
            pos_reg <= '0;
            prev_reg <= '0;
            wlen_reg <= WINDOW_RESET;
            ovalid_reg <= 1'b0;
            step_reg <= '0;
            iss_reg <= '0;
            rdv_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg <= seen_next;
            pos_reg <= pos_next;
            prev_reg <= prev_next;
            wlen_reg <= wlen_next;
            ovalid_reg <= ovalid_next;
            step_reg <= step_next;
            iss_reg <= iss_next;
            rdv_reg <= rdv_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        w_reg <= w_next;
        full_reg <= full_next;
        raddr_reg <= raddr_next;
        x1_reg <= x1_next;
        sq1_reg <= sq1_next;
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        n_reg <= n_next;
        dq_reg <= dq_next;
        drem_reg <= drem_next;
        dd_reg <= dd_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg <= acc_next;
        sval_reg <= sval_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        if (load_out)
        begin
            ovol_ok_reg <= ovol_ok_next;
            ovol_reg <= ovol_next;
            oused_reg <= oused_next;
        end
    end

    `RRV_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "block took a second item while busy")
    `RRV_ASSERT_IMPL(a_zero_when_invalid, out_valid && !volatility_valid, volatility == '0,
        "volatility not zero on an invalid result")
    `RRV_ASSERT_IMPL(a_two_returns, out_valid && volatility_valid, returns_used >= 7'd2,
        "valid result from fewer than two returns")
    `RRV_ASSERT_IMPL(a_no_read_outside_scan, ram_re, state_reg == ST_SCAN && !ram_we,
        "ring read outside the window scan")

endmodule
